[design/dlcp_pkg.sv]
// Package for the display list command processor.
// Holds opcodes, widths, lookup functions and the controller command struct.
// No dependencies.
package dlcp_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] OP_VADR   = 8'h01;
  localparam logic [7:0] OP_IADR   = 8'h02;
  localparam logic [7:0] OP_PRIM   = 8'h04;
  localparam logic [7:0] OP_JUMP   = 8'h08;
  localparam logic [7:0] OP_CALL   = 8'h0A;
  localparam logic [7:0] OP_RET    = 8'h0B;
  localparam logic [7:0] OP_END    = 8'h0C;
  localparam logic [7:0] OP_FINISH = 8'h0F;
  localparam logic [7:0] OP_BASE   = 8'h10;
  localparam logic [7:0] OP_VTYPE  = 8'h12;
  localparam logic [7:0] OP_OFFSET = 8'h13;
  localparam logic [7:0] OP_ORIGIN = 8'h14;
  localparam logic [7:0] OP_BSEL   = 8'h2A;
  localparam logic [7:0] OP_BDATA  = 8'h2B;
  localparam logic [7:0] OP_WSEL   = 8'h3A;
  localparam logic [7:0] OP_WDATA  = 8'h3B;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_BONE  = 2'd1;
  localparam logic [1:0] TGT_WORLD = 2'd2;

  localparam logic [0:0] CFG_START = 1'b0;
  localparam logic [0:0] CFG_STALL = 1'b1;

  localparam logic [31:0] WORD_MASK = 32'hFFFFFFFC;
  localparam logic [23:0] BONE_COUNT = 24'd96;
  localparam logic [23:0] WORLD_COUNT = 24'd12;

  typedef struct packed {
    logic exec;
    logic finish;
    logic write_out;
  } dp_cmd_t;

  function automatic logic [2:0] fmt_size(input logic [1:0] f);
    case (f)
      2'd0: fmt_size = 3'd0;
      2'd1: fmt_size = 3'd1;
      2'd2: fmt_size = 3'd2;
      default: fmt_size = 3'd4;
    endcase
  endfunction

  function automatic logic [1:0] fmt_pad(input logic [1:0] f);
    case (f)
      2'd2: fmt_pad = 2'd1;
      2'd3: fmt_pad = 2'd3;
      default: fmt_pad = 2'd0;
    endcase
  endfunction

  function automatic logic [2:0] col_size(input logic [2:0] c);
    case (c)
      3'd0: col_size = 3'd0;
      3'd1, 3'd2, 3'd3: col_size = 3'd1;
      3'd7: col_size = 3'd4;
      default: col_size = 3'd2;
    endcase
  endfunction

  function automatic logic [1:0] col_pad(input logic [2:0] c);
    case (c)
      3'd4, 3'd5, 3'd6: col_pad = 2'd1;
      3'd7: col_pad = 2'd3;
      default: col_pad = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] pad_to(input logic [7:0] v, input logic [1:0] p);
    pad_to = (v + {6'd0, p}) & ~{6'd0, p};
  endfunction

  // Per-vertex size before morph copies; max is 4*8+4*2+4+4*3+4*3 = 68 plus pads.
  function automatic logic [7:0] vtx_single(input logic [23:0] a);
    logic [7:0] s;
    s = 8'({5'd0, fmt_size(a[10:9])} * ({5'd0, a[16:14]} + 8'd1));
    s = pad_to(s, fmt_pad(a[1:0]));
    s = s + 8'(fmt_size(a[1:0]) * 2);
    s = pad_to(s, col_pad(a[4:2]));
    s = s + {5'd0, col_size(a[4:2])};
    s = pad_to(s, fmt_pad(a[6:5]));
    s = s + 8'(fmt_size(a[6:5]) * 3);
    s = pad_to(s, fmt_pad(a[8:7]));
    s = s + 8'(fmt_size(a[8:7]) * 3);
    vtx_single = s;
  endfunction

  function automatic logic [2:0] vtx_align(input logic [23:0] a);
    logic [2:0] m;
    m = fmt_size(a[10:9]);
    if (col_size(a[4:2]) > m) m = col_size(a[4:2]);
    if (fmt_size(a[6:5]) > m) m = fmt_size(a[6:5]);
    if (fmt_size(a[1:0]) > m) m = fmt_size(a[1:0]);
    if (fmt_size(a[8:7]) > m) m = fmt_size(a[8:7]);
    vtx_align = m;
  endfunction

endpackage

[design/dlcp_if.sv]
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface dlcp_if #(parameter int W = 32) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/display_list_command_processor_top.sv]
// Display list command processor: input word {opcode, argument} in, one result
// word out per command.
// Channels: in (valid/ready, opcode+argument), out (valid/ready, nine fields).
// Config: cfg_we, cfg_index, cfg_data; index 0 list start, 1 stall address.
// An accepted command enters the execute state and its result shows valid in the
// output state that follows. Accepting latches the command, reads the call stack
// memory and forms the address and stride or index-size product; leaving execute
// commits. A new command is taken in the same cycle the pending result is taken.
// Reset: synchronous, rst_n low; all pointers, flags and the stack count clear.
// Stall: while a result waits and out_ready is low, it holds; no command is taken.
// Depends on dlcp_pkg, dlcp_if, dlcp_ctrl, dlcp_dp.
module display_list_command_processor_top (
  input  logic        clk,
  input  logic        rst_n,
  dlcp_if.sink        in_ch,
  dlcp_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dlcp_pkg::dp_cmd_t  cmd;
  logic [31:0] nfa, vba, ipa, wv;
  logic [9:0]  vs;
  logic        dn;
  logic [1:0]  ss, tg;
  logic [6:0]  wi;

  dlcp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd)
  );

  dlcp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .op_in(in_ch.data[31:24]), .arg_in(in_ch.data[23:0]),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .o_next(nfa), .o_vbase(vba), .o_iptr(ipa), .o_stride(vs), .o_done(dn),
    .o_status(ss), .o_tgt(tg), .o_widx(wi), .o_wval(wv)
  );

  assign out_ch.data = {nfa, vba, ipa, vs, dn, ss, tg, wi, wv};

endmodule

[design/dlcp_ctrl.sv]
// Controller state machine for the command processor.
// Depends on dlcp_pkg.
module dlcp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dlcp_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   seen_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = in_valid ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = (state_r == S_OUT);
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_OUT) && out_ready);
  assign cmd.exec = in_valid && in_ready;
  assign cmd.finish = (state_r == S_EXEC);
  assign cmd.write_out = (state_r == S_EXEC) && seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.exec) seen_r <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_exec_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_OUT) else $error("exec not followed by out");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_ready) |=> state_r == S_OUT) else $error("out dropped");
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> state_r == S_EXEC) else $error("accept lost");
  a_done_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_r) else $error("output without item");
`endif

endmodule

[design/dlcp_dp.sv]
// Datapath: list state, pointers, stride, call stack and result register.
// Depends on dlcp_pkg.
module dlcp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  dlcp_pkg::dp_cmd_t  cmd,
  input  logic [7:0]         op_in,
  input  logic [23:0]        arg_in,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  output logic [31:0]        o_next,
  output logic [31:0]        o_vbase,
  output logic [31:0]        o_iptr,
  output logic [9:0]         o_stride,
  output logic               o_done,
  output logic [1:0]         o_status,
  output logic [1:0]         o_tgt,
  output logic [6:0]         o_widx,
  output logic [31:0]        o_wval
);

  logic [31:0] list_r, stall_r, offset_r, vbase_r, iptr_r;
  logic [7:0]  base_r;
  logic [1:0]  ifmt_r;
  logic [9:0]  stride_r;
  logic [dlcp_pkg::CNT_W-1:0] cnt_r;
  logic        ended_r, finished_r;
  logic [23:0] bidx_r, widx_r;

  logic [7:0]  op_r;
  logic [23:0] arg_r;
  logic        run_r;
  logic [31:0] cmdaddr_r, prod_r;
  logic [31:0] ret_q, off_q;
  logic [7:0]  vs_single_r;
  logic [2:0]  vs_align_r;
  logic [3:0]  vs_morph_r;

  logic [31:0] return_stack [dlcp_pkg::STACK_DEPTH];
  logic [31:0] offset_stack [dlcp_pkg::STACK_DEPTH];

  logic done_now;
  assign done_now = ended_r ? finished_r : (list_r >= stall_r);

  logic [dlcp_pkg::SP_W-1:0] rd_ptr;
  assign rd_ptr = dlcp_pkg::SP_W'(cnt_r - 1'b1);

  logic use_idx;
  assign use_idx = (iptr_r != 32'd0) && (ifmt_r != 2'd0);

  // Stage 1: latch command, compute address, product and stack read.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      op_r <= op_in;
      arg_r <= arg_in;
      run_r <= !done_now;
      cmdaddr_r <= {base_r, arg_in} + offset_r;
      prod_r <= use_idx ? 32'({29'd0, dlcp_pkg::fmt_size(ifmt_r)} * {16'd0, arg_in[15:0]})
                        : 32'({22'd0, stride_r} * {16'd0, arg_in[15:0]});
      ret_q <= return_stack[rd_ptr];
      off_q <= offset_stack[rd_ptr];
      vs_single_r <= dlcp_pkg::vtx_single(arg_in);
      vs_align_r <= dlcp_pkg::vtx_align(arg_in);
      vs_morph_r <= {1'b0, arg_in[20:18]} + 4'd1;
    end
  end

  logic [31:0] la4;
  assign la4 = list_r + 32'd4;
  logic [10:0] vs_full;
  logic [9:0]  vs_fin;
  always_comb begin
    vs_full = 11'({3'd0, vs_single_r} * {7'd0, vs_morph_r});
    if (vs_align_r == 3'd0) vs_fin = 10'd0;
    else vs_fin = 10'((vs_full + 11'(vs_align_r) - 11'd1) & ~(11'(vs_align_r) - 11'd1));
  end

  logic [1:0]  status_n, tgt_n;
  logic [6:0]  widx_n;
  logic [31:0] wval_n;
  logic        push, ok_ret;
  always_comb begin
    status_n = dlcp_pkg::ST_OK;
    tgt_n = dlcp_pkg::TGT_NONE;
    widx_n = 7'd0;
    wval_n = 32'd0;
    push = 1'b0;
    ok_ret = 1'b0;
    if (run_r) begin
      case (op_r)
        dlcp_pkg::OP_CALL: begin
          if (cnt_r >= dlcp_pkg::CNT_W'(dlcp_pkg::STACK_DEPTH)) status_n = dlcp_pkg::ST_FULL;
          else push = 1'b1;
        end
        dlcp_pkg::OP_RET: begin
          if (cnt_r == '0) status_n = dlcp_pkg::ST_EMPTY;
          else ok_ret = 1'b1;
        end
        dlcp_pkg::OP_BDATA: if (bidx_r < dlcp_pkg::BONE_COUNT) begin
          tgt_n = dlcp_pkg::TGT_BONE;
          widx_n = bidx_r[6:0];
          wval_n = {arg_r, 8'd0};
        end
        dlcp_pkg::OP_WDATA: if (widx_r < dlcp_pkg::WORLD_COUNT) begin
          tgt_n = dlcp_pkg::TGT_WORLD;
          widx_n = widx_r[6:0];
          wval_n = {arg_r, 8'd0};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && push) begin
      return_stack[cnt_r[dlcp_pkg::SP_W-1:0]] <= la4;
      offset_stack[cnt_r[dlcp_pkg::SP_W-1:0]] <= offset_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_r <= '0; stall_r <= '0; offset_r <= '0; vbase_r <= '0; iptr_r <= '0;
      base_r <= '0; ifmt_r <= '0; stride_r <= '0; cnt_r <= '0;
      ended_r <= 1'b0; finished_r <= 1'b0; bidx_r <= '0; widx_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          dlcp_pkg::CFG_START: begin
            list_r <= cfg_data; ended_r <= 1'b0; finished_r <= 1'b0;
          end
          dlcp_pkg::CFG_STALL: stall_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish && run_r) begin
        list_r <= la4;
        case (op_r)
          dlcp_pkg::OP_VADR: vbase_r <= cmdaddr_r;
          dlcp_pkg::OP_IADR: iptr_r <= cmdaddr_r;
          dlcp_pkg::OP_PRIM: if (use_idx) iptr_r <= iptr_r + prod_r;
                             else vbase_r <= vbase_r + prod_r;
          dlcp_pkg::OP_JUMP: list_r <= cmdaddr_r & dlcp_pkg::WORD_MASK;
          dlcp_pkg::OP_CALL: if (push) begin
            cnt_r <= cnt_r + 1'b1;
            list_r <= cmdaddr_r & dlcp_pkg::WORD_MASK;
          end
          dlcp_pkg::OP_RET: if (ok_ret) begin
            cnt_r <= cnt_r - 1'b1;
            list_r <= ret_q;
            offset_r <= off_q;
          end
          dlcp_pkg::OP_END: ended_r <= 1'b1;
          dlcp_pkg::OP_FINISH: finished_r <= 1'b1;
          dlcp_pkg::OP_BASE: base_r <= arg_r[23:16];
          dlcp_pkg::OP_VTYPE: begin
            ifmt_r <= arg_r[12:11];
            stride_r <= vs_fin;
          end
          dlcp_pkg::OP_OFFSET: offset_r <= {arg_r, 8'd0};
          dlcp_pkg::OP_ORIGIN: offset_r <= list_r;
          dlcp_pkg::OP_BSEL: bidx_r <= arg_r;
          dlcp_pkg::OP_BDATA: if (tgt_n != dlcp_pkg::TGT_NONE) bidx_r <= bidx_r + 24'd1;
          dlcp_pkg::OP_WSEL: widx_r <= arg_r;
          dlcp_pkg::OP_WDATA: if (tgt_n != dlcp_pkg::TGT_NONE) widx_r <= widx_r + 24'd1;
          default: ;
        endcase
      end
    end
  end

  // Result register, loaded at the same edge as the state update.
  logic wr_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) wr_d_r <= 1'b0;
    else wr_d_r <= cmd.write_out;
    if (cmd.write_out) begin
      o_status <= status_n;
      o_tgt <= tgt_n;
      o_widx <= widx_n;
      o_wval <= wval_n;
    end
  end

  assign o_next = list_r;
  assign o_vbase = vbase_r;
  assign o_iptr = iptr_r;
  assign o_stride = stride_r;
  assign o_done = done_now;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dlcp_pkg::CNT_W'(dlcp_pkg::STACK_DEPTH)) else $error("stack count overflow");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r < dlcp_pkg::CNT_W'(dlcp_pkg::STACK_DEPTH)) else $error("push on full");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ok_ret |-> cnt_r != '0) else $error("pop on empty");
  a_wr_d: assert property (@(posedge clk) disable iff (!rst_n)
    wr_d_r |-> $past(cmd.finish)) else $error("result load out of step");
`endif

endmodule

[verif/tb_display_list_command_processor_top.sv]
// Testbench for display_list_command_processor_top: random and directed commands
// on the input channel, each result checked against a predictor of the processor.
// Depends on dlcp_pkg, dlcp_if and the design files.
`timescale 1ns / 100ps

module tb_display_list_command_processor_top;

  typedef struct packed {
    logic [31:0] fetch;
    logic [31:0] vbase;
    logic [31:0] iptr;
    logic [9:0]  stride;
    logic        done;
    logic [1:0]  status;
    logic [1:0]  target;
    logic [6:0]  widx;
    logic [31:0] wval;
  } cmd_result_t;

  class cmd_scoreboard;
    bit [31:0] start_addr, stall_addr, list_addr, offset, vbase, iptr;
    bit [7:0]  base_hi;
    bit [1:0]  idx_fmt;
    bit [9:0]  stride;
    bit [31:0] ret_stk[dlcp_pkg::STACK_DEPTH];
    bit [31:0] off_stk[dlcp_pkg::STACK_DEPTH];
    int unsigned depth;
    bit ended, finished;
    bit [23:0] bone_idx, world_idx;
    cmd_result_t pending[$];
    int errors;

    function int unsigned fsz(bit [1:0] f);
      int unsigned t[4] = '{0, 1, 2, 4};
      return t[f];
    endfunction

    function int unsigned fpad(bit [1:0] f);
      int unsigned t[4] = '{0, 0, 1, 3};
      return t[f];
    endfunction

    function int unsigned csz(bit [2:0] c);
      int unsigned t[8] = '{0, 1, 1, 1, 2, 2, 2, 4};
      return t[c];
    endfunction

    function int unsigned cpad(bit [2:0] c);
      int unsigned t[8] = '{0, 0, 0, 0, 1, 1, 1, 3};
      return t[c];
    endfunction

    function bit [31:0] align(bit [31:0] v, bit [31:0] p);
      return (v + p) & ~p;
    endfunction

    function bit [9:0] stride_of(bit [23:0] a);
      bit [31:0] s, al;
      s = fsz(a[10:9]) * (a[16:14] + 1);
      s = align(s, fpad(a[1:0])) + fsz(a[1:0]) * 2;
      s = align(s, cpad(a[4:2])) + csz(a[4:2]);
      s = align(s, fpad(a[6:5])) + fsz(a[6:5]) * 3;
      s = align(s, fpad(a[8:7])) + fsz(a[8:7]) * 3;
      s = s * (a[20:18] + 1);
      al = fsz(a[10:9]);
      if (csz(a[4:2]) > al) al = csz(a[4:2]);
      if (fsz(a[6:5]) > al) al = fsz(a[6:5]);
      if (fsz(a[1:0]) > al) al = fsz(a[1:0]);
      if (fsz(a[8:7]) > al) al = fsz(a[8:7]);
      if (al == 0) return 0;
      s = (s + al - 1) & ~(al - 1);
      return s[9:0];
    endfunction

    function bit is_done();
      if (ended) return finished;
      return list_addr >= stall_addr;
    endfunction

    function bit [31:0] addr_of(bit [23:0] arg);
      return ({base_hi, 24'd0} | {8'd0, arg}) + offset;
    endfunction

    function void write_reg(bit idx, bit [31:0] v);
      if (idx == dlcp_pkg::CFG_START) begin
        start_addr = v;
        list_addr = v;
        ended = 0;
        finished = 0;
      end else begin
        stall_addr = v;
      end
    endfunction

    function void note_command(bit [7:0] op, bit [23:0] arg);
      cmd_result_t r;
      r = '0;
      if (!is_done()) begin
        list_addr += 4;
        case (op)
          dlcp_pkg::OP_VADR: vbase = addr_of(arg);
          dlcp_pkg::OP_IADR: iptr = addr_of(arg);
          dlcp_pkg::OP_PRIM: begin
            if (iptr != 0 && idx_fmt != 0) iptr += fsz(idx_fmt) * arg[15:0];
            else vbase += arg[15:0] * stride;
          end
          dlcp_pkg::OP_JUMP: list_addr = addr_of(arg) & dlcp_pkg::WORD_MASK;
          dlcp_pkg::OP_CALL: begin
            if (depth >= dlcp_pkg::STACK_DEPTH) begin
              r.status = dlcp_pkg::ST_FULL;
            end else begin
              ret_stk[depth] = list_addr;
              off_stk[depth] = offset;
              depth++;
              list_addr = addr_of(arg) & dlcp_pkg::WORD_MASK;
            end
          end
          dlcp_pkg::OP_RET: begin
            if (depth == 0) begin
              r.status = dlcp_pkg::ST_EMPTY;
            end else begin
              depth--;
              list_addr = ret_stk[depth];
              offset = off_stk[depth];
            end
          end
          dlcp_pkg::OP_END: ended = 1;
          dlcp_pkg::OP_FINISH: finished = 1;
          dlcp_pkg::OP_BASE: base_hi = arg[23:16];
          dlcp_pkg::OP_VTYPE: begin
            idx_fmt = arg[12:11];
            stride = stride_of(arg);
          end
          dlcp_pkg::OP_OFFSET: offset = {arg, 8'd0};
          dlcp_pkg::OP_ORIGIN: offset = list_addr - 4;
          dlcp_pkg::OP_BSEL: bone_idx = arg;
          dlcp_pkg::OP_BDATA: begin
            if (bone_idx < dlcp_pkg::BONE_COUNT) begin
              r.target = dlcp_pkg::TGT_BONE;
              r.widx = bone_idx[6:0];
              r.wval = {arg, 8'd0};
              bone_idx = bone_idx + 1;
            end
          end
          dlcp_pkg::OP_WSEL: world_idx = arg;
          dlcp_pkg::OP_WDATA: begin
            if (world_idx < dlcp_pkg::WORLD_COUNT) begin
              r.target = dlcp_pkg::TGT_WORLD;
              r.widx = world_idx[6:0];
              r.wval = {arg, 8'd0};
              world_idx = world_idx + 1;
            end
          end
          default: ;
        endcase
      end
      r.fetch = list_addr;
      r.vbase = vbase;
      r.iptr = iptr;
      r.stride = stride;
      r.done = is_done();
      pending.push_back(r);
    endfunction

    function void check_result(cmd_result_t got);
      cmd_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.fetch !== e.fetch) begin
        $error("next_fetch_address exp %h got %h", e.fetch, got.fetch); errors++;
      end
      if (got.vbase !== e.vbase) begin
        $error("vertex_base_address exp %h got %h", e.vbase, got.vbase); errors++;
      end
      if (got.iptr !== e.iptr) begin
        $error("index_pointer_address exp %h got %h", e.iptr, got.iptr); errors++;
      end
      if (got.stride !== e.stride) begin
        $error("vertex_stride exp %0d got %0d", e.stride, got.stride); errors++;
      end
      if (got.done !== e.done) begin
        $error("list_done exp %0d got %0d", e.done, got.done); errors++;
      end
      if (got.status !== e.status) begin
        $error("stack_status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.target !== e.target) begin
        $error("matrix_write_target exp %0d got %0d", e.target, got.target); errors++;
      end
      if (got.widx !== e.widx) begin
        $error("matrix_write_index exp %0d got %0d", e.widx, got.widx); errors++;
      end
      if (got.wval !== e.wval) begin
        $error("matrix_write_value exp %h got %h", e.wval, got.wval); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [0:0] cfg_index = dlcp_pkg::CFG_START;
  logic [31:0] cfg_data = '0;

  dlcp_if #(.W(32)) in_ch (clk);
  dlcp_if #(.W($bits(cmd_result_t))) out_ch (clk);

  display_list_command_processor_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cmd_scoreboard sb = new();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_cmd(bit [7:0] op, bit [23:0] arg);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= {op, arg};
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_command(op, arg);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [31:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic random_cmd();
    bit [7:0] ops[16] = '{dlcp_pkg::OP_VADR, dlcp_pkg::OP_IADR, dlcp_pkg::OP_PRIM,
      dlcp_pkg::OP_JUMP, dlcp_pkg::OP_CALL, dlcp_pkg::OP_RET, dlcp_pkg::OP_END,
      dlcp_pkg::OP_FINISH, dlcp_pkg::OP_BASE, dlcp_pkg::OP_VTYPE, dlcp_pkg::OP_OFFSET,
      dlcp_pkg::OP_ORIGIN, dlcp_pkg::OP_BSEL, dlcp_pkg::OP_BDATA, dlcp_pkg::OP_WSEL,
      dlcp_pkg::OP_WDATA};
    bit [7:0] op;
    bit [23:0] arg;
    op = ops[$urandom_range(0, 15)];
    if ($urandom_range(0, 9) == 0) op = 8'($urandom_range(0, 255));
    if (op == dlcp_pkg::OP_FINISH && $urandom_range(0, 2) != 0) op = dlcp_pkg::OP_PRIM;
    arg = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 1023) << 2);
    if (op == dlcp_pkg::OP_BASE && $urandom_range(0, 3) != 0)
      arg = 24'($urandom_range(0, 65535));
    if ((op == dlcp_pkg::OP_BSEL || op == dlcp_pkg::OP_WSEL) && $urandom_range(0, 3) != 0)
      arg = 24'($urandom_range(0, 100));
    send_cmd(op, arg);
  endtask

  initial begin : rx
    int stall;
    wait (rst_n);
    forever begin
      stall = $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      sb.check_result(cmd_result_t'(out_ch.data));
    end
  end

  initial begin : stim
    bit [31:0] st;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_cmd(dlcp_pkg::OP_PRIM, 24'd1);
    drain();
    write_reg(dlcp_pkg::CFG_STALL, 32'hFFFF_FFFF);
    write_reg(dlcp_pkg::CFG_START, 32'h0000_0100);
    send_cmd(dlcp_pkg::OP_VADR, 24'hFF_FFFF);
    send_cmd(dlcp_pkg::OP_BASE, 24'hFF_0000);
    send_cmd(dlcp_pkg::OP_IADR, 24'h00_0010);
    send_cmd(dlcp_pkg::OP_BASE, 24'h00_0000);
    send_cmd(dlcp_pkg::OP_VTYPE, 24'hFF_FFFF);
    send_cmd(dlcp_pkg::OP_PRIM, 24'hFF_FFFF);
    send_cmd(dlcp_pkg::OP_VTYPE, 24'h00_0000);
    send_cmd(dlcp_pkg::OP_PRIM, 24'h00_0005);
    send_cmd(dlcp_pkg::OP_VTYPE, 24'h00_09BF);
    send_cmd(dlcp_pkg::OP_OFFSET, 24'h00_0040);
    send_cmd(dlcp_pkg::OP_ORIGIN, 24'h00_0000);
    send_cmd(dlcp_pkg::OP_RET, 24'h00_0000);
    send_cmd(dlcp_pkg::OP_CALL, 24'h00_0803);
    send_cmd(dlcp_pkg::OP_JUMP, 24'h00_1002);
    send_cmd(dlcp_pkg::OP_RET, 24'h00_0000);
    send_cmd(dlcp_pkg::OP_BSEL, 24'd95);
    send_cmd(dlcp_pkg::OP_BDATA, 24'hFF_FFFF);
    send_cmd(dlcp_pkg::OP_BDATA, 24'h12_3456);
    send_cmd(dlcp_pkg::OP_WSEL, 24'd11);
    send_cmd(dlcp_pkg::OP_WDATA, 24'hAB_CDEF);
    send_cmd(dlcp_pkg::OP_WDATA, 24'h00_0001);
    send_cmd(8'hFF, 24'h00_0000);
    send_cmd(dlcp_pkg::OP_FINISH, 24'd0);
    send_cmd(dlcp_pkg::OP_END, 24'd0);
    send_cmd(dlcp_pkg::OP_FINISH, 24'd0);
    send_cmd(dlcp_pkg::OP_VADR, 24'd4);
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: st = $urandom_range(0, 4095) << 2;
        1: st = 32'hFFFF_FFFC;
        default: st = $urandom & dlcp_pkg::WORD_MASK;
      endcase
      if (ph == 5) write_reg(dlcp_pkg::CFG_STALL, 32'h0000_0000);
      else if (ph % 3 == 2) write_reg(dlcp_pkg::CFG_STALL, st + $urandom_range(40, 800));
      else write_reg(dlcp_pkg::CFG_STALL, 32'hFFFF_FFFF);
      write_reg(dlcp_pkg::CFG_START, ph == 1 ? 32'h0 : st);
      if (ph == 3) begin
        repeat (66) send_cmd(dlcp_pkg::OP_CALL, 24'($urandom_range(0, 4095) << 2));
        repeat (67) send_cmd(dlcp_pkg::OP_RET, 24'($urandom));
      end
      repeat (90) random_cmd();
      drain();
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

[files.f]
design/dlcp_pkg.sv
design/dlcp_if.sv
design/dlcp_ctrl.sv
design/dlcp_dp.sv
design/display_list_command_processor_top.sv
verif/tb_display_list_command_processor_top.sv
